/* hdl/cdt_pkg.sv */
// Package with command codes and field widths for the countdown timer bank.
`timescale 1ns / 1ps

package cdt_pkg;

  localparam int CMD_W   = 2;
  localparam int CHAN_W  = 3;
  localparam int COUNT_W = 16;

  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam cmd_t CMD_WAIT  = 2'd0;
  localparam cmd_t CMD_RESET = 2'd1;
  localparam cmd_t CMD_TICK  = 2'd2;

endpackage

/* hdl/countdown_timer_bank_core.sv */
// Top level of the countdown timer bank: command decode, count memory and tick walk.
`timescale 1ns / 1ps

// Usage
// A command beat is taken at a rising edge where start is high and busy is low.
// Every command answers with exactly one result beat: out_valid is high for one
// cycle and out_done_res holds the answer. The receiver cannot stall, so the
// result is simply presented for that one cycle and then dropped.
// Latency and throughput:
//   reset, unused codes, a wait on an out-of-range channel and a wait that
//   starts an idle channel answer in the cycle after acceptance, and busy stays
//   low, so a new command can follow every cycle.
//   A wait on a running channel reads its count from the memory first; S_WAIT
//   registers the answer from the read data, and busy is high for one cycle.
//   A tick walks every channel through the single read port of the count
//   memory, one entry per cycle, writing each entry back in the cycle after
//   its read; the answer comes at the end of the walk.
// Reset (rst_n low, synchronous) stops every channel and empties the result
// strobe. Counts are left as they are; a channel only reads its count once a
// wait has loaded it.
module countdown_timer_bank_core #(
  parameter int NUM_TIMERS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  cdt_pkg::cmd_t        in_command,
  input  cdt_pkg::chan_t       in_channel,
  input  cdt_pkg::count_t      in_delay_ms,
  input  cdt_pkg::count_t      in_elapsed_ms,
  output logic                 out_valid,
  output logic                 out_done_res
);

  import cdt_pkg::*;

  // Index width for the bank and a counter that can also hold NUM_TIMERS.
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [NUM_TIMERS-1:0] run_r, run_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  tick_rv_r, tick_rv_nxt;
  logic [IDX_W-1:0]      tick_idx_r, tick_idx_nxt;
  logic [IDX_W-1:0]      ch_idx_r, ch_idx_nxt;
  count_t                elapsed_r, elapsed_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_done_r, out_done_nxt;

  // Count memory: one write port, one read port, registered read data.
  count_t                mem [NUM_TIMERS];
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  count_t                mem_wd;
  logic [IDX_W-1:0]      mem_ra;
  count_t                rd_data_r;

  logic                  accept;
  logic                  ch_ok;
  logic [IDX_W-1:0]      ch_idx;
  logic                  cnt_more;

  assign accept   = start && (state_r == S_IDLE);
  assign ch_ok    = 32'(in_channel) < NUM_TIMERS;
  assign ch_idx   = IDX_W'(in_channel);
  assign cnt_more = 32'(cnt_r) < NUM_TIMERS;

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_done_res = out_done_r;

  // In idle the read port looks at the addressed channel, so a wait on a
  // running channel has its count ready in the following cycle.
  assign mem_ra = (state_r == S_TICK) ? cnt_r[IDX_W-1:0] : ch_idx;

  always_comb begin
    state_nxt     = state_r;
    run_nxt       = run_r;
    cnt_nxt       = cnt_r;
    tick_rv_nxt   = 1'b0;
    tick_idx_nxt  = tick_idx_r;
    ch_idx_nxt    = ch_idx_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = 1'b0;
    out_done_nxt  = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = ch_idx;
    mem_wd        = in_delay_ms;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_WAIT: begin
              if (ch_ok && !run_r[ch_idx]) begin
                // Idle channel: load the delay and start it.
                mem_we          = 1'b1;
                run_nxt[ch_idx] = 1'b1;
                out_valid_nxt   = 1'b1;
              end else if (ch_ok) begin
                ch_idx_nxt = ch_idx;
                state_nxt  = S_WAIT;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            CMD_RESET: begin
              if (ch_ok) begin
                run_nxt[ch_idx] = 1'b0;
              end
              out_valid_nxt = 1'b1;
            end
            CMD_TICK: begin
              elapsed_nxt = in_elapsed_ms;
              cnt_nxt     = '0;
              state_nxt   = S_TICK;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_WAIT: begin
        // The running channel's count is on the read port now.
        if (rd_data_r == '0) begin
          run_nxt[ch_idx_r] = 1'b0;
          out_done_nxt      = 1'b1;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_TICK: begin
        // Read entry cnt_r while writing back the entry read in the previous cycle.
        if (cnt_more) begin
          tick_rv_nxt  = 1'b1;
          tick_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt      = cnt_r + 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
        if (tick_rv_r && run_r[tick_idx_r] && (rd_data_r != '0)) begin
          mem_we = 1'b1;
          mem_wa = tick_idx_r;
          mem_wd = (rd_data_r > elapsed_r) ? count_t'(rd_data_r - elapsed_r) : '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= '0;
      cnt_r       <= '0;
      tick_rv_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      cnt_r       <= cnt_nxt;
      tick_rv_r   <= tick_rv_nxt;
      out_valid_r <= out_valid_nxt;
      out_done_r  <= out_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tick_idx_r <= tick_idx_nxt;
    ch_idx_r   <= ch_idx_nxt;
    elapsed_r  <= elapsed_nxt;
  end

`ifndef ASSERT_OFF
  // A result beat only follows an accepted command or the end of a multi-cycle one.
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(start && !busy) || ($past(state_r) != S_IDLE))
    else $error("result beat without a command");

  // Done is only answered by a wait that found its running channel's count at zero.
  a_done_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_done_r |-> out_valid_r && ($past(state_r) == S_WAIT) && ($past(rd_data_r) == '0))
    else $error("done without an expired wait");

  // A done answer leaves its channel stopped.
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT && rd_data_r == '0) |=> !run_r[$past(ch_idx_r)])
    else $error("expired channel still running");

  // The tick walk never runs past the bank.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK) |-> 32'(cnt_r) <= NUM_TIMERS)
    else $error("tick walk overran the bank");
`endif

endmodule
